FILE: sv/channel_number_allocator_top_defines.svh
// Assertion shorthands used by the checker file.
`ifndef CHANNEL_NUMBER_ALLOCATOR_TOP_DEFINES_SVH
`define CHANNEL_NUMBER_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define CNA_ASSERT_IMPLY(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("channel allocator check failed");

// Next-cycle implication.
`define CNA_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("channel allocator check failed");

`endif

FILE: sv/cna_pkg.sv
`default_nettype none

package cna_pkg;

  localparam int ACTION_W = 2;
  localparam int CHAN_W   = 6;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 7;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Register index taken from the word address bit.
  localparam logic REG_CHANNEL_LIMIT = 1'b0;

  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_IDX = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_LOOK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/cna_if.sv
`default_nettype none

interface cna_req_if;
  logic                           valid;
  logic                           ready;
  logic [cna_pkg::ACTION_W-1:0]   action;
  logic [cna_pkg::CHAN_W-1:0]     channel_in;
  logic [cna_pkg::TAG_W-1:0]      tag_in;

  modport source (output valid, action, channel_in, tag_in, input ready);
  modport sink   (input valid, action, channel_in, tag_in, output ready);
endinterface

interface cna_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cna_pkg::STATUS_W-1:0]   status;
  logic [cna_pkg::CHAN_W-1:0]     channel_out;
  logic                           occupied;
  logic [cna_pkg::TAG_W-1:0]      tag_out;

  modport source (output valid, status, channel_out, occupied, tag_out, input ready);
  modport sink   (input valid, status, channel_out, occupied, tag_out, output ready);
endinterface

`default_nettype wire

FILE: sv/channel_number_allocator_top.sv
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   action, channel_in, tag_in
// rsp       out  valid/ready   status, channel_out, occupied, tag_out
// apb       in   psel/penable  channel_limit at byte address 0
//
// One item at a time: free, an unused code or a lookup at/above the mark go
// to DONE; a lookup below it reads the slot in LOOK; allocate steps through
// SCAN and CHECK from the low hint to reuse a free slot, grow or report full.
// Reset clears the state, hint, high-water mark and output valid, not the slot
// memory; slots at or above the mark are never read, so no clearing pass.
// A waiting result sits in the output register while the next item is taken.
`default_nettype none

module channel_number_allocator_top #(
  parameter int CHANNELS = 64,
  parameter int TAG_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cna_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [cna_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [cna_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  cna_req_if.sink                               req,
  cna_rsp_if.source                             rsp
);

  localparam int IDX_W = $clog2(CHANNELS);
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CMP_W = (CNT_W > cna_pkg::LIMIT_W) ? CNT_W : cna_pkg::LIMIT_W;
  localparam int SW    = (TAG_BITS < cna_pkg::TAG_W) ? TAG_BITS : cna_pkg::TAG_W;

  logic [cna_pkg::LIMIT_W-1:0] channel_limit;

  cna_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .channel_limit (channel_limit)
  );

  // Slot memory: busy bit on top of the tag.
  logic [SW:0]      mem [CHANNELS];
  logic [SW:0]      rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [SW:0]      mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  cna_pkg::state_t state, state_next;

  logic [SW-1:0]                tag, tag_next;
  logic [CNT_W-1:0]             idx, idx_next;
  logic [CNT_W-1:0]             low_hint, low_hint_next;
  logic [CNT_W-1:0]             high_water, high_water_next;
  logic [cna_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [cna_pkg::CHAN_W-1:0]   res_chan, res_chan_next;
  logic                         res_occ, res_occ_next;
  logic [SW-1:0]                res_tag, res_tag_next;

  logic                         out_valid;
  logic                         out_load;
  logic [cna_pkg::STATUS_W-1:0] out_status;
  logic [cna_pkg::CHAN_W-1:0]   out_chan;
  logic                         out_occ;
  logic [SW-1:0]                out_tag;

  logic [CMP_W-1:0] in_ch_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] hw_ext;
  logic [CMP_W-1:0] hint_ext;
  logic [CMP_W-1:0] lim_ext;
  logic [CMP_W-1:0] eff_limit;

  assign in_ch_ext = CMP_W'(req.channel_in);
  assign idx_ext   = CMP_W'(idx);
  assign hw_ext    = CMP_W'(high_water);
  assign hint_ext  = CMP_W'(low_hint);
  assign lim_ext   = CMP_W'(channel_limit);
  assign eff_limit = (lim_ext > CMP_W'(CHANNELS)) ? CMP_W'(CHANNELS) : lim_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cna_pkg::ST_IDLE;
      low_hint   <= '0;
      high_water <= '0;
    end else begin
      state      <= state_next;
      low_hint   <= low_hint_next;
      high_water <= high_water_next;
    end
  end

  always_ff @(posedge clk) begin
    tag        <= tag_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_chan   <= res_chan_next;
    res_occ    <= res_occ_next;
    res_tag    <= res_tag_next;
  end

  always_comb begin
    state_next      = state;
    tag_next        = tag;
    idx_next        = idx;
    low_hint_next   = low_hint;
    high_water_next = high_water;
    res_status_next = res_status;
    res_chan_next   = res_chan;
    res_occ_next    = res_occ;
    res_tag_next    = res_tag;
    mem_we          = 1'b0;
    mem_waddr       = idx[IDX_W-1:0];
    mem_wdata       = {1'b1, tag};
    mem_re          = 1'b0;
    mem_raddr       = idx[IDX_W-1:0];
    out_load        = 1'b0;
    req.ready       = 1'b0;

    unique case (state)
      cna_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          tag_next        = req.tag_in[SW-1:0];
          res_status_next = cna_pkg::STATUS_OK;
          res_chan_next   = req.channel_in;
          res_occ_next    = 1'b0;
          res_tag_next    = '0;
          state_next      = cna_pkg::ST_DONE;
          unique case (req.action)
            cna_pkg::ACT_ALLOC: begin
              idx_next   = low_hint;
              state_next = cna_pkg::ST_SCAN;
            end
            cna_pkg::ACT_FREE: begin
              if (in_ch_ext >= hw_ext) begin
                res_status_next = cna_pkg::STATUS_BAD_IDX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_ch_ext[IDX_W-1:0];
                mem_wdata = '0;
                if (in_ch_ext < hint_ext) begin
                  low_hint_next = in_ch_ext[CNT_W-1:0];
                end
              end
            end
            cna_pkg::ACT_LOOKUP: begin
              if (in_ch_ext < hw_ext) begin
                mem_re     = 1'b1;
                mem_raddr  = in_ch_ext[IDX_W-1:0];
                state_next = cna_pkg::ST_LOOK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cna_pkg::ST_SCAN: begin
        if (idx_ext < hw_ext) begin
          mem_re     = 1'b1;
          state_next = cna_pkg::ST_CHECK;
        end else if (hw_ext >= eff_limit) begin
          res_status_next = cna_pkg::STATUS_NO_FREE;
          res_chan_next   = '0;
          state_next      = cna_pkg::ST_DONE;
        end else begin
          // Grow: take the slot at the high-water mark.
          mem_we          = 1'b1;
          mem_waddr       = high_water[IDX_W-1:0];
          low_hint_next   = high_water + 1'b1;
          high_water_next = high_water + 1'b1;
          res_chan_next   = hw_ext[cna_pkg::CHAN_W-1:0];
          state_next      = cna_pkg::ST_DONE;
        end
      end

      cna_pkg::ST_CHECK: begin
        if (!rd_data[SW]) begin
          mem_we        = 1'b1;
          low_hint_next = idx + 1'b1;
          res_chan_next = idx_ext[cna_pkg::CHAN_W-1:0];
          state_next    = cna_pkg::ST_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = cna_pkg::ST_SCAN;
        end
      end

      cna_pkg::ST_LOOK: begin
        res_occ_next = rd_data[SW];
        res_tag_next = rd_data[SW] ? rd_data[SW-1:0] : '0;
        state_next   = cna_pkg::ST_DONE;
      end

      cna_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = cna_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cna_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_chan   <= res_chan;
      out_occ    <= res_occ;
      out_tag    <= res_tag;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.channel_out = out_chan;
  assign rsp.occupied    = out_occ;
  assign rsp.tag_out     = cna_pkg::TAG_W'(out_tag);

endmodule

`default_nettype wire

FILE: sv/cna_apb_regs.sv
`default_nettype none

module cna_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cna_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [cna_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [cna_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output logic      [cna_pkg::LIMIT_W-1:0]      channel_limit
);

  logic sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[2] == cna_pkg::REG_CHANNEL_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_limit <= cna_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && sel_limit) begin
      channel_limit <= pwdata[cna_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = cna_pkg::APB_DATA_W'(channel_limit);
    end
  end

endmodule

`default_nettype wire

FILE: sv/cna_checker.sv
`default_nettype none
`include "channel_number_allocator_top_defines.svh"

module cna_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             rsp_valid,
  input wire logic                             rsp_ready,
  input wire logic [cna_pkg::STATUS_W-1:0]     status,
  input wire logic [cna_pkg::CHAN_W-1:0]       channel_out,
  input wire logic                             occupied,
  input wire logic [cna_pkg::TAG_W-1:0]        tag_out
);

  // A stalled item holds.
  `CNA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(channel_out) && $stable(occupied) && $stable(tag_out))

  // Full table reports number zero and no lookup data.
  `CNA_ASSERT_IMPLY(a_full_clean, clk, rst, rsp_valid && status == cna_pkg::STATUS_NO_FREE, channel_out == '0 && !occupied && tag_out == '0)

  // A tag only shows for an occupied slot, and occupancy only on success.
  `CNA_ASSERT_IMPLY(a_tag_occ, clk, rst, rsp_valid && (tag_out != '0 || occupied), occupied && status == cna_pkg::STATUS_OK)

  // Nothing is offered right after reset.
  `CNA_ASSERT_IMPLY(a_reset_quiet, clk, 1'b0, $past(rst), !rsp_valid)

endmodule

bind channel_number_allocator_top cna_checker u_cna_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .channel_out (rsp.channel_out),
  .occupied    (rsp.occupied),
  .tag_out     (rsp.tag_out)
);

`default_nettype wire

FILE: tb/tb_channel_number_allocator_top.sv
`timescale 1ns / 1ps

module tb_channel_number_allocator_top;

  localparam int NUM_CHANNELS = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * NUM_CHANNELS + 8;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 60;

  localparam logic [cna_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [cna_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {cna_pkg::REG_CHANNEL_LIMIT, 2'b00};

  typedef struct packed {
    logic [cna_pkg::STATUS_W-1:0] status;
    logic [cna_pkg::CHAN_W-1:0]   channel_out;
    logic                         occupied;
    logic [cna_pkg::TAG_W-1:0]    tag_out;
  } chan_result_t;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cna_pkg::APB_ADDR_W-1:0] paddr;
  logic [cna_pkg::APB_DATA_W-1:0] pwdata;
  logic [cna_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  cna_req_if req_if ();
  cna_rsp_if rsp_if ();

  channel_number_allocator_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  // Mirror of the allocator table.
  bit                          busy_map [NUM_CHANNELS];
  logic [cna_pkg::TAG_W-1:0]   tag_map [NUM_CHANNELS];
  int                          hint_mark;
  int                          high_mark;
  logic [cna_pkg::LIMIT_W-1:0] limit_value;

  chan_result_t expected_results[$];
  int           error_count;
  bit           idle_on;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic chan_result_t predict_channel_result(
      input logic [cna_pkg::ACTION_W-1:0] act,
      input logic [cna_pkg::CHAN_W-1:0] ch,
      input logic [cna_pkg::TAG_W-1:0] tg);
    chan_result_t res;
    int           slot;
    int           lim;
    bit           found;
    res.status      = cna_pkg::STATUS_OK;
    res.channel_out = ch;
    res.occupied    = 1'b0;
    res.tag_out     = '0;
    lim = (int'(limit_value) > NUM_CHANNELS) ? NUM_CHANNELS : int'(limit_value);
    case (act)
      cna_pkg::ACT_ALLOC: begin
        found = 1'b0;
        slot  = hint_mark;
        while (!found && slot < high_mark && slot < NUM_CHANNELS) begin
          if (!busy_map[slot]) found = 1'b1;
          else slot++;
        end
        if (found) begin
          hint_mark = slot + 1;
        end else begin
          if (slot < high_mark) slot = high_mark;
          if (slot >= lim) begin
            res.status = cna_pkg::STATUS_NO_FREE;
            slot = 0;
          end else begin
            hint_mark = slot + 1;
            high_mark = slot + 1;
          end
        end
        if (res.status == cna_pkg::STATUS_OK) begin
          busy_map[slot] = 1'b1;
          tag_map[slot]  = tg;
        end
        res.channel_out = slot[cna_pkg::CHAN_W-1:0];
      end
      cna_pkg::ACT_FREE: begin
        if (int'(ch) >= high_mark) begin
          res.status = cna_pkg::STATUS_BAD_IDX;
        end else begin
          busy_map[ch] = 1'b0;
          if (int'(ch) < hint_mark) hint_mark = int'(ch);
        end
      end
      cna_pkg::ACT_LOOKUP: begin
        if (int'(ch) < high_mark && busy_map[ch]) begin
          res.occupied = 1'b1;
          res.tag_out  = tag_map[ch];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Hold valid after acceptance; the next call either lowers it or swaps the payload.
  task automatic send_request(input logic [cna_pkg::ACTION_W-1:0] act,
                              input logic [cna_pkg::CHAN_W-1:0] ch,
                              input logic [cna_pkg::TAG_W-1:0] tg);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.action     = act;
    req_if.channel_in = ch;
    req_if.tag_in     = tg;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(predict_channel_result(act, ch, tg));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_channel_limit(input logic [cna_pkg::LIMIT_W-1:0] lim);
    logic [cna_pkg::APB_DATA_W-1:0] rd;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LIMIT_ADDR;
    pwdata  = ($urandom() & ~32'h7F) | cna_pkg::APB_DATA_W'(lim);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    limit_value = lim;
    // Read back right after the write.
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[cna_pkg::LIMIT_W-1:0] !== lim)
      note_failure($sformatf("channel_limit readback expected %0d got %0d", lim,
                             rd[cna_pkg::LIMIT_W-1:0]));
  endtask

  task automatic test_empty_table();
    send_request(cna_pkg::ACT_LOOKUP, 6'd0, 16'h0000);
    send_request(cna_pkg::ACT_FREE, 6'd0, 16'hFFFF);
    send_request(ACT_UNUSED, 6'd63, 16'hFFFF);
    send_request(cna_pkg::ACT_LOOKUP, 6'd63, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_zero_limit();
    write_channel_limit(7'd0);
    send_request(cna_pkg::ACT_ALLOC, 6'd63, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_single_slot();
    write_channel_limit(7'd1);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hFFFF);
    send_request(cna_pkg::ACT_ALLOC, 6'd63, 16'h1234);
    send_request(cna_pkg::ACT_LOOKUP, 6'd0, 16'h0000);
    send_request(cna_pkg::ACT_FREE, 6'd0, 16'h0000);
    // Free a slot that is already free.
    send_request(cna_pkg::ACT_FREE, 6'd0, 16'h0000);
    send_request(cna_pkg::ACT_LOOKUP, 6'd0, 16'hFFFF);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'h0000);
    send_request(cna_pkg::ACT_FREE, 6'd63, 16'h0000);
    send_request(cna_pkg::ACT_LOOKUP, 6'd0, 16'h0000);
    drain_results();
  endtask

  task automatic test_hint_reuse();
    write_channel_limit(7'd4);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hA001);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hA002);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hA003);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hA004);
    send_request(cna_pkg::ACT_FREE, 6'd2, 16'h0000);
    send_request(cna_pkg::ACT_FREE, 6'd1, 16'h0000);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'h5A5A);
    send_request(cna_pkg::ACT_LOOKUP, 6'd2, 16'h0000);
    send_request(cna_pkg::ACT_LOOKUP, 6'd3, 16'h0000);
    send_request(cna_pkg::ACT_ALLOC, 6'd0, 16'hC3C3);
    send_request(cna_pkg::ACT_LOOKUP, 6'd2, 16'h0000);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int                           phase_limits[RANDOM_PHASES];
    int                           alloc_weight;
    int                           r;
    logic [cna_pkg::ACTION_W-1:0] act;
    logic [cna_pkg::CHAN_W-1:0]   ch;
    phase_limits = '{2, 9, 20, 0, 33, 1, 50, 64, 127, 0};
    phase_limits[RANDOM_PHASES-1] = $urandom_range(1, 64);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_channel_limit(phase_limits[p][cna_pkg::LIMIT_W-1:0]);
      idle_on = (p != 3 && p != 7);
      alloc_weight = (phase_limits[p] >= 48) ? 75 : int'($urandom_range(35, 65));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_weight) act = cna_pkg::ACT_ALLOC;
        else if (r < alloc_weight + (100 - alloc_weight) / 2) act = cna_pkg::ACT_FREE;
        else if (r < 96) act = cna_pkg::ACT_LOOKUP;
        else act = ACT_UNUSED;
        // Aim mostly at live slots, now and then anywhere.
        if (high_mark > 0 && $urandom_range(0, 9) < 8)
          ch = cna_pkg::CHAN_W'($urandom_range(0, high_mark - 1));
        else
          ch = cna_pkg::CHAN_W'($urandom());
        send_request(act, ch, cna_pkg::TAG_W'($urandom()));
      end
      drain_results();
    end
  endtask

  // Receiver side: random backpressure.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    chan_result_t got;
    chan_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.status, rsp_if.channel_out, rsp_if.occupied, rsp_if.tag_out};
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected item status=%0d ch=%0d occ=%0d tag=%h",
                               got.status, got.channel_out, got.occupied, got.tag_out));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.channel_out !== want.channel_out ||
            got.occupied !== want.occupied || got.tag_out !== want.tag_out)
          note_failure($sformatf(
            "expected status=%0d ch=%0d occ=%0d tag=%h, got status=%0d ch=%0d occ=%0d tag=%h",
            want.status, want.channel_out, want.occupied, want.tag_out,
            got.status, got.channel_out, got.occupied, got.tag_out));
      end
    end
  end

  // Count cycles without any accepted item or register access.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.action     = cna_pkg::ACT_ALLOC;
    req_if.channel_in = '0;
    req_if.tag_in     = '0;
    error_count       = 0;
    quiet_cycles      = 0;
    idle_on           = 1'b1;
    hint_mark         = 0;
    high_mark         = 0;
    limit_value       = cna_pkg::LIMIT_RESET;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      busy_map[k] = 1'b0;
      tag_map[k]  = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_zero_limit();
    test_single_slot();
    test_hint_reuse();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
